/* src/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int PAT_BYTES       = 32;
	localparam int PAT_WORDS       = 4;
	localparam int LEN_W           = 6;
	localparam int ADDR_W          = 32;
	localparam int APB_DATA_W      = 64;
	localparam int APB_ADDR_W      = 6;
	localparam int REG_SEL_LSB     = 3;
	localparam int REG_SEL_W       = 3;

	localparam logic [7:0]        WILDCARD_BYTE = 8'h3F;
	localparam logic [LEN_W-1:0]  LEN_RESET     = LEN_W'(1);

	typedef enum logic [REG_SEL_W-1:0] {
		REG_PAT0   = 3'd0,
		REG_PAT1   = 3'd1,
		REG_PAT2   = 3'd2,
		REG_PAT3   = 3'd3,
		REG_LENGTH = 3'd4,
		REG_BASE   = 3'd5,
		REG_OFFSET = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [PAT_WORDS-1:0][APB_DATA_W-1:0] pattern;
		logic [LEN_W-1:0]                     length;
		logic [ADDR_W-1:0]                    base;
		logic [ADDR_W-1:0]                    offset;
	} cfg_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} result_t;

endpackage

`default_nettype wire

/* src/wbps_in_if.sv */
// ----------------------------------------------------------------------------
// wbps_in_if
// Image byte channel: one image byte and its end-of-image mark per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] image_byte;
	logic       last_byte;

	modport source (output valid, output image_byte, output last_byte, input ready);
	modport sink   (input valid, input image_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* src/wbps_out_if.sv */
// ----------------------------------------------------------------------------
// wbps_out_if
// Result channel: found flag and match address per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbps_out_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [wbps_pkg::ADDR_W-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

/* src/wbps_cfg.sv */
// ----------------------------------------------------------------------------
// wbps_cfg
// APB register file: pattern words, pattern length, image base, offset.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [wbps_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [wbps_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [wbps_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output wbps_pkg::cfg_t                       cfg
);

	wbps_pkg::cfg_t                   cfg_q;
	logic [wbps_pkg::REG_SEL_W-1:0]   sel;
	logic                             wr_en;

	assign sel    = paddr[wbps_pkg::REG_SEL_LSB +: wbps_pkg::REG_SEL_W];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern <= '0;
			cfg_q.length  <= wbps_pkg::LEN_RESET;
			cfg_q.base    <= '0;
			cfg_q.offset  <= '0;
		end else if (wr_en) begin
			case (sel)
				wbps_pkg::REG_PAT0:   cfg_q.pattern[0] <= pwdata;
				wbps_pkg::REG_PAT1:   cfg_q.pattern[1] <= pwdata;
				wbps_pkg::REG_PAT2:   cfg_q.pattern[2] <= pwdata;
				wbps_pkg::REG_PAT3:   cfg_q.pattern[3] <= pwdata;
				wbps_pkg::REG_LENGTH: cfg_q.length <= pwdata[wbps_pkg::LEN_W-1:0];
				wbps_pkg::REG_BASE:   cfg_q.base   <= pwdata[wbps_pkg::ADDR_W-1:0];
				wbps_pkg::REG_OFFSET: cfg_q.offset <= pwdata[wbps_pkg::ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			wbps_pkg::REG_PAT0:   prdata = cfg_q.pattern[0];
			wbps_pkg::REG_PAT1:   prdata = cfg_q.pattern[1];
			wbps_pkg::REG_PAT2:   prdata = cfg_q.pattern[2];
			wbps_pkg::REG_PAT3:   prdata = cfg_q.pattern[3];
			wbps_pkg::REG_LENGTH: prdata = wbps_pkg::APB_DATA_W'(cfg_q.length);
			wbps_pkg::REG_BASE:   prdata = wbps_pkg::APB_DATA_W'(cfg_q.base);
			wbps_pkg::REG_OFFSET: prdata = wbps_pkg::APB_DATA_W'(cfg_q.offset);
			default:              prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

/* src/wbps_cell.sv */
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds one image byte, shifts it to the next cell on each
// beat and checks the incoming byte against its aligned pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell #(
	parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF,
	parameter int IDX         = 0
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                shift,
	input  wire logic [7:0]                          d_in,
	input  wire logic [wbps_pkg::PAT_BYTES*8-1:0]    pattern,
	input  wire logic [$clog2(PATTERN_MAX+1)-1:0]    length,
	output logic      [7:0]                          q,
	output logic                                     ok
);

	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic [7:0]    byte_q;
	logic [LW-1:0] pidx;
	logic [4:0]    psel;
	logic [7:0]    pbyte;
	logic          in_use;
	logic          wild;

	// pattern position that lines up with this cell for the current length
	assign in_use = int'(length) > IDX;
	assign pidx   = LW'(int'(length) - 1 - IDX);
	assign psel   = 5'(pidx);
	assign pbyte  = pattern[psel*8 +: 8];
	assign wild   = (int'(pidx) >= wbps_pkg::PAT_BYTES) || (pbyte == wbps_pkg::WILDCARD_BYTE);
	assign ok     = !in_use || wild || (pbyte == d_in);
	assign q      = byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d_in;
		end
	end

endmodule

`default_nettype wire

/* src/wbps_out_buf.sv */
// ----------------------------------------------------------------------------
// wbps_out_buf
// Result output register with one skid entry behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire wbps_pkg::result_t push_data,
	output logic                   full,
	wbps_out_if.source             report
);

	logic              out_valid_q;
	logic              skid_valid_q;
	wbps_pkg::result_t out_q;
	wbps_pkg::result_t skid_q;
	logic              take;

	assign take                 = out_valid_q && report.ready;
	assign full                 = skid_valid_q;
	assign report.valid         = out_valid_q;
	assign report.found         = out_q.found;
	assign report.match_address = out_q.match_address;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (take) begin
			if (skid_valid_q) begin
				out_q        <= skid_q;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				out_q <= push_data;
			end else begin
				out_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_q       <= push_data;
				out_valid_q <= 1'b1;
			end else begin
				skid_q       <= push_data;
				skid_valid_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/wildcard_byte_pattern_scan.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Streams an image one byte per beat through a chain of window cells and
// reports the first wildcard signature match, or not-found at image end.
//
//   channel  | dir | beat contents               | handshake
//   ---------+-----+-----------------------------+-----------
//   scan     | in  | image_byte, last_byte       | valid/ready
//   report   | out | found, match_address        | valid/ready
//   apb      | in  | pattern, length, base, offs | psel/penable
//
// One byte per cycle while scan.ready is high; all cell compares run in parallel per beat.
// A result is written to the output register, or to the skid entry if that is full, as its byte is taken.
// scan.ready drops only while the output and skid entries are both full.
// Reset clears the window, the position count, the done flag and the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_scan #(
	parameter int PATTERN_MAX = wbps_pkg::PATTERN_MAX_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [wbps_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [wbps_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [wbps_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	wbps_in_if.sink                              scan,
	wbps_out_if.source                           report
);

	localparam int LW = $clog2(PATTERN_MAX + 1);

	wbps_pkg::cfg_t                  cfg;
	wbps_pkg::result_t               res;
	logic [wbps_pkg::PAT_BYTES*8-1:0] pattern;
	logic [LW-1:0]                   eff_len;
	logic [7:0]                      win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0]          ok;
	logic [wbps_pkg::ADDR_W-1:0]     pos_q;
	logic [wbps_pkg::ADDR_W-1:0]     count_next;
	logic                            done_q;
	logic                            buf_full;
	logic                            accept;
	logic                            hit;
	logic                            emit;

	wbps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign pattern = cfg.pattern;

	always_comb begin
		if (cfg.length == '0) begin
			eff_len = LW'(1);
		end else if (int'(cfg.length) > PATTERN_MAX) begin
			eff_len = LW'(PATTERN_MAX);
		end else begin
			eff_len = LW'(cfg.length);
		end
	end

	assign scan.ready = !buf_full;
	assign accept     = scan.valid && scan.ready;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		logic [7:0] d_in;
		if (j == 0) begin : g_head
			assign d_in = scan.image_byte;
		end else begin : g_link
			assign d_in = win[j-1];
		end
		wbps_cell #(
			.PATTERN_MAX (PATTERN_MAX),
			.IDX         (j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (accept),
			.d_in    (d_in),
			.pattern (pattern),
			.length  (eff_len),
			.q       (win[j]),
			.ok      (ok[j])
		);
	end

	assign count_next = pos_q + 1'b1;
	assign hit  = !done_q && (count_next >= wbps_pkg::ADDR_W'(eff_len)) && (&ok);
	assign emit = accept && (hit || (scan.last_byte && !done_q));

	always_comb begin
		res.found = hit;
		if (hit) begin
			res.match_address = cfg.base + (count_next - wbps_pkg::ADDR_W'(eff_len))
				+ cfg.offset;
		end else begin
			res.match_address = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (scan.last_byte) begin
				pos_q  <= '0;
				done_q <= 1'b0;
			end else begin
				pos_q  <= count_next;
				done_q <= done_q || hit;
			end
		end
	end

	wbps_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (res),
		.full      (buf_full),
		.report    (report)
	);

endmodule

`default_nettype wire

/* src/wbps_checker.sv */
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks on the scanner: result hold, not-found address,
// back-pressure source and configuration port readiness.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        pready,
	input wire logic                        scan_ready,
	input wire logic                        report_valid,
	input wire logic                        report_ready,
	input wire logic                        report_found,
	input wire logic [wbps_pkg::ADDR_W-1:0] report_match_address
);

	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> report_valid && $stable(report_found)
			&& $stable(report_match_address))
		else $error("stalled report beat changed");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_found |-> report_match_address == '0)
		else $error("not-found beat carries nonzero address");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_ready |-> report_valid)
		else $error("scan stalled with no pending report");

	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.pready               (pready),
	.scan_ready           (scan.ready),
	.report_valid         (report.valid),
	.report_ready         (report.ready),
	.report_found         (report.found),
	.report_match_address (report.match_address)
);

`default_nettype wire

/* test/tb_wildcard_byte_pattern_scan.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scan
// Drives byte images into the scanner and checks every found / not-found
// report against an in-bench signature scanner, with source gaps, sink
// stalls, a long sink hold-off and register writes between and within images.
// ----------------------------------------------------------------------------

module tb_wildcard_byte_pattern_scan;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [wbps_pkg::APB_ADDR_W-1:0] paddr;
	logic [wbps_pkg::APB_DATA_W-1:0] pwdata;
	logic [wbps_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	wbps_in_if  scan_ch();
	wbps_out_if report_ch();

	wildcard_byte_pattern_scan dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.scan    (scan_ch),
		.report  (report_ch)
	);

	// signature scanner copy: configuration
	logic [63:0]                 sig_words [wbps_pkg::PAT_WORDS];
	logic [wbps_pkg::LEN_W-1:0]  sig_len;
	logic [wbps_pkg::ADDR_W-1:0] img_base;
	logic [wbps_pkg::ADDR_W-1:0] res_offset;

	// signature scanner copy: scan state
	logic [7:0]                  win_bytes [wbps_pkg::PATTERN_MAX_DEF];
	logic [31:0]                 img_pos;
	logic                        hit_seen;

	wbps_pkg::result_t           expected_reports [$];
	wbps_pkg::result_t           want;
	int unsigned                 mismatch_count;
	int unsigned                 src_idle_pct;
	int unsigned                 rcv_stall_pct;
	int unsigned                 rcv_hold_cycles;

	const wbps_pkg::reg_idx_t    sig_regs [wbps_pkg::PAT_WORDS] = '{wbps_pkg::REG_PAT0,
		wbps_pkg::REG_PAT1, wbps_pkg::REG_PAT2, wbps_pkg::REG_PAT3};

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int unsigned eff_len();
		if (sig_len == 0)
			return 1;
		if (sig_len > wbps_pkg::PATTERN_MAX_DEF)
			return wbps_pkg::PATTERN_MAX_DEF;
		return int'(sig_len);
	endfunction

	function automatic logic [7:0] sig_byte(input int unsigned k);
		return sig_words[k / 8][(k % 8) * 8 +: 8];
	endfunction

	function automatic void predict_scan(input logic [7:0] b, input logic last);
		int unsigned       len;
		logic              hit;
		logic [7:0]        pb;
		wbps_pkg::result_t res;
		len = eff_len();
		for (int k = wbps_pkg::PATTERN_MAX_DEF - 1; k > 0; k--)
			win_bytes[k] = win_bytes[k - 1];
		win_bytes[0] = b;
		img_pos = img_pos + 1;
		if (!hit_seen && img_pos >= len) begin
			hit = 1'b1;
			for (int k = 0; k < len; k++) begin
				pb = sig_byte(k);
				if (pb != wbps_pkg::WILDCARD_BYTE && pb != win_bytes[len - 1 - k])
					hit = 1'b0;
			end
			if (hit) begin
				hit_seen = 1'b1;
				res.found = 1'b1;
				res.match_address = img_base + (img_pos - 32'(len)) + res_offset;
				expected_reports.insert(expected_reports.size(), res);
			end
		end
		if (last) begin
			if (!hit_seen) begin
				res.found = 1'b0;
				res.match_address = '0;
				expected_reports.insert(expected_reports.size(), res);
			end
			foreach (win_bytes[k])
				win_bytes[k] = 8'h00;
			img_pos = '0;
			hit_seen = 1'b0;
		end
	endfunction

	always @(negedge clk) begin
		if (rcv_hold_cycles != 0) begin
			report_ch.ready <= 1'b0;
			rcv_hold_cycles = rcv_hold_cycles - 1;
		end else begin
			report_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && report_ch.valid && report_ch.ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected beat: found %0d match_address 0x%08h",
					report_ch.found, report_ch.match_address);
				mismatch_count++;
			end else begin
				want = expected_reports.pop_front();
				if (report_ch.found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, report_ch.found);
					mismatch_count++;
				end
				if (report_ch.match_address !== want.match_address) begin
					$error("match_address: expected 0x%08h, actual 0x%08h",
						want.match_address, report_ch.match_address);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			scan_ch.valid <= 1'b0;
			@(negedge clk);
		end
		scan_ch.valid      <= 1'b1;
		scan_ch.image_byte <= b;
		scan_ch.last_byte  <= last;
		do @(posedge clk); while (!scan_ch.ready);
		predict_scan(b, last);
	endtask

	// drop valid, then hold until every pending report has come back
	task automatic drain_reports();
		@(negedge clk);
		scan_ch.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input wbps_pkg::reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= wbps_pkg::APB_ADDR_W'(idx) << wbps_pkg::REG_SEL_LSB;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			wbps_pkg::REG_PAT0:   sig_words[0] = value;
			wbps_pkg::REG_PAT1:   sig_words[1] = value;
			wbps_pkg::REG_PAT2:   sig_words[2] = value;
			wbps_pkg::REG_PAT3:   sig_words[3] = value;
			wbps_pkg::REG_LENGTH: sig_len = value[wbps_pkg::LEN_W-1:0];
			wbps_pkg::REG_BASE:   img_base = value[wbps_pkg::ADDR_W-1:0];
			wbps_pkg::REG_OFFSET: res_offset = value[wbps_pkg::ADDR_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_addr();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 2)
			return 32'h0000_0000;
		if (r < 4)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	task automatic pick_signature();
		logic [63:0] w;
		int unsigned len;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			len = $urandom_range(1, 4);
		else if (r < 80)
			len = $urandom_range(5, 12);
		else if (r < 92)
			len = $urandom_range(13, 32);
		else
			len = $urandom_range(0, 63);
		for (int k = 0; k < wbps_pkg::PAT_WORDS; k++) begin
			w = {$urandom, $urandom};
			for (int j = 0; j < 8; j++) begin
				if ($urandom_range(3) == 0)
					w[j * 8 +: 8] = wbps_pkg::WILDCARD_BYTE;
				else if ($urandom_range(1) == 0)
					w[j * 8 +: 8] = 8'($urandom_range(0, 3));
			end
			write_reg(sig_regs[k], w);
		end
		write_reg(wbps_pkg::REG_LENGTH, 64'(len));
		write_reg(wbps_pkg::REG_BASE, 64'(pick_addr()));
		write_reg(wbps_pkg::REG_OFFSET, 64'(pick_addr()));
	endtask

	task automatic send_image(input int unsigned n, input bit plant);
		logic [7:0]  img [$];
		int unsigned len;
		int unsigned at;
		logic [7:0]  pb;
		len = eff_len();
		for (int i = 0; i < n; i++)
			img.insert(img.size(),
				($urandom_range(9) < 4) ? 8'($urandom_range(0, 3)) : 8'($urandom));
		if (plant && len <= n) begin
			at = $urandom_range(0, n - len);
			for (int k = 0; k < len; k++) begin
				pb = sig_byte(k);
				if (pb != wbps_pkg::WILDCARD_BYTE)
					img[at + k] = pb;
			end
		end
		foreach (img[i])
			send_byte(img[i], i == n - 1);
	endtask

	task automatic test_reset_defaults();
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain_reports();
	endtask

	task automatic test_address_wrap();
		write_reg(wbps_pkg::REG_BASE, 64'hFFFF_FFFF);
		write_reg(wbps_pkg::REG_OFFSET, 64'hFFFF_FFFF);
		write_reg(wbps_pkg::REG_LENGTH, 64'd0);
		write_reg(wbps_pkg::REG_PAT0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain_reports();
	endtask

	task automatic test_short_image();
		for (int k = 0; k < wbps_pkg::PAT_WORDS; k++)
			write_reg(sig_regs[k], {8{wbps_pkg::WILDCARD_BYTE}});
		write_reg(wbps_pkg::REG_LENGTH, 64'd63);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hFF, 1'b1);
		drain_reports();
		write_reg(wbps_pkg::REG_LENGTH, 64'd33);
		send_byte(8'h3F, 1'b1);
		drain_reports();
	endtask

	task automatic test_midimage_write();
		write_reg(wbps_pkg::REG_LENGTH, 64'd2);
		write_reg(wbps_pkg::REG_PAT0, 64'h0000_0000_0000_BBAA);
		write_reg(wbps_pkg::REG_BASE, 64'h0000_0100);
		write_reg(wbps_pkg::REG_OFFSET, 64'd0);
		send_byte(8'hAA, 1'b0);
		drain_reports();
		write_reg(wbps_pkg::REG_PAT0, 64'h0000_0000_0000_CCAA);
		send_byte(8'hCC, 1'b1);
		drain_reports();
	endtask

	task automatic test_backpressure();
		src_idle_pct  = 0;
		rcv_stall_pct = 0;
		write_reg(wbps_pkg::REG_LENGTH, 64'd1);
		write_reg(wbps_pkg::REG_PAT0, 64'(wbps_pkg::WILDCARD_BYTE));
		write_reg(wbps_pkg::REG_BASE, 64'h8000_0000);
		write_reg(wbps_pkg::REG_OFFSET, 64'h0000_0010);
		rcv_hold_cycles = 80;
		for (int i = 0; i < 16; i++)
			send_byte(8'($urandom), 1'b1);
		drain_reports();
	endtask

	task automatic test_random_images(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned n_bytes);
		int unsigned sent;
		int unsigned len;
		int unsigned n;
		src_idle_pct  = idle_pct;
		rcv_stall_pct = stall_pct;
		sent = 0;
		pick_signature();
		while (sent < n_bytes) begin
			len = eff_len();
			if ($urandom_range(99) < 15)
				n = $urandom_range(1, len);
			else
				n = $urandom_range(len, len + 10);
			send_image(n, $urandom_range(99) < 70);
			sent += n;
			if ($urandom_range(4) == 0) begin
				drain_reports();
				pick_signature();
			end
		end
		drain_reports();
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		scan_ch.valid      = 1'b0;
		scan_ch.image_byte = 8'h00;
		scan_ch.last_byte  = 1'b0;
		report_ch.ready    = 1'b0;
		src_idle_pct       = 0;
		rcv_stall_pct      = 0;
		rcv_hold_cycles    = 0;
		mismatch_count     = 0;
		foreach (sig_words[k])
			sig_words[k] = '0;
		sig_len    = wbps_pkg::LEN_RESET;
		img_base   = '0;
		res_offset = '0;
		foreach (win_bytes[k])
			win_bytes[k] = 8'h00;
		img_pos  = '0;
		hit_seen = 1'b0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_address_wrap();
		test_short_image();
		test_midimage_write();
		test_backpressure();
		test_random_images(0, 0, 100);
		test_random_images(45, 0, 100);
		test_random_images(0, 45, 100);
		test_random_images(34, 34, 100);

		drain_reports();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
src/wbps_pkg.sv
src/wbps_in_if.sv
src/wbps_out_if.sv
src/wbps_cfg.sv
src/wbps_cell.sv
src/wbps_out_buf.sv
src/wildcard_byte_pattern_scan.sv
src/wbps_checker.sv
test/tb_wildcard_byte_pattern_scan.sv
